>>> hw/rtl/rfdr_pkg.sv
// Package for the receive frame descriptor ring: sizes, field widths,
// status codes, request and result types, ring index helper.
// No dependencies; every other file of the block uses it.
package rfdr_pkg;

    // Ring and buffer geometry
    localparam int DESC_COUNT  = 8;
    localparam int BURST_BYTES = 256;
    localparam int BUF_BYTES   = 1024;

    // Field widths fixed by the channel format
    localparam int IDX_W    = $clog2(DESC_COUNT);
    localparam int BYTES_W  = 9;
    localparam int STATUS_W = 2;
    localparam int OFFS_W   = 10;
    localparam int LEN_W    = 11;

    // Width of intermediate offset sums (holds start plus a full burst)
    localparam int SUM_W = 18;

    // Command codes
    localparam logic CMD_BURST_END = 1'b0;
    localparam logic CMD_RELEASE   = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [OFFS_W-1:0] offs_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE      = 2'd0,
        STATUS_COMMIT    = 2'd1,
        STATUS_RING_FULL = 2'd2,
        STATUS_COLLIDE   = 2'd3
    } status_t;

    typedef struct packed {
        logic               cmd;
        logic [BYTES_W-1:0] received_bytes;
    } event_t;

    typedef struct packed {
        status_t            status;
        logic               head_valid;
        offs_t              head_start;
        logic [LEN_W-1:0]   head_length;
        offs_t              burst_start;
    } result_t;

    // Advance a ring index with wrap at the ring size
    function automatic idx_t ring_next(input idx_t i);
        idx_t n;
        if (i == idx_t'(DESC_COUNT - 1))
            n = '0;
        else
            n = i + idx_t'(1);
        return n;
    endfunction

endpackage

>>> hw/rtl/rfdr_event_if.sv
// Request channel of the descriptor ring: valid/ready plus the event fields.
// Depends on rfdr_pkg for field widths.
interface rfdr_event_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [rfdr_pkg::BYTES_W-1:0] received_bytes;

    modport source (output valid, output cmd, output received_bytes, input ready);
    modport sink   (input valid, input cmd, input received_bytes, output ready);
endinterface

>>> hw/rtl/rfdr_result_if.sv
// Result channel of the descriptor ring: valid/ready plus the result fields.
// Depends on rfdr_pkg for field widths.
interface rfdr_result_if;
    logic                          valid;
    logic                          ready;
    logic [rfdr_pkg::STATUS_W-1:0] status;
    logic                          head_valid;
    logic [rfdr_pkg::OFFS_W-1:0]   head_start;
    logic [rfdr_pkg::LEN_W-1:0]    head_length;
    logic [rfdr_pkg::OFFS_W-1:0]   burst_start;

    modport source (output valid, output status, output head_valid, output head_start,
                    output head_length, output burst_start, input ready);
    modport sink   (input valid, input status, input head_valid, input head_start,
                    input head_length, input burst_start, output ready);
endinterface

>>> hw/rtl/rx_frame_descriptor_ring.sv
// Top level of the receive frame descriptor ring: request register,
// ring update (rfdr_ring) and result register.
// Depends on rfdr_pkg, rfdr_event_if, rfdr_result_if and rfdr_ring.
//
// Usage:
//   event_ch carries one request per handshake: cmd 0 closes a receive burst
//   of received_bytes bytes, cmd 1 releases the oldest held frame.
//   result_ch returns exactly one result per request, in order: status,
//   the oldest held frame (head_valid, head_start, head_length) and the
//   offset where the next burst begins.
//   A taken request passes through the request register and then the
//   result register before its result shows valid on result_ch.
//   Throughput: one request per cycle while result_ch is not stalled; the
//   ring update is a single pass of logic between the two registers, so each
//   request sees the state left by the one before it.
//   Reset empties the ring, clears all descriptors and puts the next burst at
//   offset 0.
//   When result_ch stalls, the result register holds its value, the request
//   register holds one more request, and event_ch ready drops until the
//   result is taken.
module rx_frame_descriptor_ring (
    input logic           clk,
    input logic           rst_n,
    rfdr_event_if.sink    event_ch,
    rfdr_result_if.source result_ch
);

    logic              req_valid_reg;
    rfdr_pkg::event_t  req_reg;
    logic              res_valid_reg;
    rfdr_pkg::result_t res_reg;
    rfdr_pkg::result_t res_comb;
    logic              advance;
    logic              req_take;

    // Move a request into the result stage when that stage is free
    assign advance  = req_valid_reg && (!res_valid_reg || result_ch.ready);
    assign event_ch.ready = !req_valid_reg || advance;
    assign req_take = event_ch.valid && event_ch.ready;

    rfdr_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .ev    (req_reg),
        .res   (res_comb)
    );

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (req_take)
            req_valid_reg <= 1'b1;
        else if (advance)
            req_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg.cmd            <= event_ch.cmd;
            req_reg.received_bytes <= event_ch.received_bytes;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (result_ch.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_comb;
    end

    assign result_ch.valid       = res_valid_reg;
    assign result_ch.status      = res_reg.status;
    assign result_ch.head_valid  = res_reg.head_valid;
    assign result_ch.head_start  = res_reg.head_start;
    assign result_ch.head_length = res_reg.head_length;
    assign result_ch.burst_start = res_reg.burst_start;

endmodule

>>> hw/rtl/rfdr_ring.sv
// Descriptor ring state and the single-pass update for one request.
// Depends on rfdr_pkg. Result is combinational from state and the request.
module rfdr_ring (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rfdr_pkg::event_t  ev,
    output rfdr_pkg::result_t res
);

    // Ring pointers, next burst start, a copy of the oldest descriptor and the table
    rfdr_pkg::idx_t  write_idx_reg, write_idx_next;
    rfdr_pkg::idx_t  read_idx_reg, read_idx_next;
    rfdr_pkg::offs_t burst_start_reg, burst_start_next;
    rfdr_pkg::offs_t head_start_reg, head_start_next;
    rfdr_pkg::offs_t head_end_reg, head_end_next;
    rfdr_pkg::offs_t desc_start_reg [rfdr_pkg::DESC_COUNT];
    rfdr_pkg::offs_t desc_end_reg   [rfdr_pkg::DESC_COUNT];

    logic              ring_empty;
    logic              ring_full;
    logic              wrap;
    logic              collide;
    logic              commit;
    logic              release_head;
    rfdr_pkg::idx_t    write_idx_adv;
    rfdr_pkg::idx_t    read_idx_adv;
    rfdr_pkg::sum_t    len_sat;
    rfdr_pkg::sum_t    end_sum;
    rfdr_pkg::sum_t    next_sum;
    rfdr_pkg::offs_t   frame_end;
    rfdr_pkg::offs_t   oldest_start;
    rfdr_pkg::status_t status;

    // Work out the frame end, wrap, drop reasons and the next state
    always_comb
    begin
        ring_empty    = (write_idx_reg == read_idx_reg);
        write_idx_adv = rfdr_pkg::ring_next(write_idx_reg);
        read_idx_adv  = rfdr_pkg::ring_next(read_idx_reg);
        ring_full     = (write_idx_adv == read_idx_reg);

        // Clamp the byte count to one burst
        len_sat = rfdr_pkg::sum_t'(ev.received_bytes);
        if (len_sat > rfdr_pkg::sum_t'(rfdr_pkg::BURST_BYTES))
            len_sat = rfdr_pkg::sum_t'(rfdr_pkg::BURST_BYTES);

        // Clamp the end to the last buffer byte
        end_sum = rfdr_pkg::sum_t'(burst_start_reg) + len_sat - rfdr_pkg::sum_t'(1);
        if (end_sum > rfdr_pkg::sum_t'(rfdr_pkg::BUF_BYTES - 1))
            end_sum = rfdr_pkg::sum_t'(rfdr_pkg::BUF_BYTES - 1);
        frame_end = end_sum[rfdr_pkg::OFFS_W-1:0];
        next_sum  = end_sum + rfdr_pkg::sum_t'(1);

        // Wrap when a full burst no longer fits; check against the oldest frame
        wrap = (next_sum + rfdr_pkg::sum_t'(rfdr_pkg::BURST_BYTES - 1))
               > rfdr_pkg::sum_t'(rfdr_pkg::BUF_BYTES - 1);
        oldest_start = ring_empty ? burst_start_reg : head_start_reg;
        collide = wrap && (rfdr_pkg::sum_t'(rfdr_pkg::BURST_BYTES - 1)
                           >= rfdr_pkg::sum_t'(oldest_start));

        commit       = 1'b0;
        release_head = 1'b0;
        status       = rfdr_pkg::STATUS_NONE;
        if (ev.cmd == rfdr_pkg::CMD_BURST_END)
        begin
            if (ev.received_bytes != '0)
            begin
                if (ring_full)
                    status = rfdr_pkg::STATUS_RING_FULL;
                else if (collide)
                    status = rfdr_pkg::STATUS_COLLIDE;
                else
                begin
                    status = rfdr_pkg::STATUS_COMMIT;
                    commit = 1'b1;
                end
            end
        end
        else
        begin
            release_head = !ring_empty;
        end

        write_idx_next   = write_idx_reg;
        read_idx_next    = read_idx_reg;
        burst_start_next = burst_start_reg;
        head_start_next  = head_start_reg;
        head_end_next    = head_end_reg;
        if (commit)
        begin
            write_idx_next   = write_idx_adv;
            burst_start_next = wrap ? '0 : next_sum[rfdr_pkg::OFFS_W-1:0];
            if (ring_empty)
            begin
                head_start_next = burst_start_reg;
                head_end_next   = frame_end;
            end
        end
        if (release_head)
        begin
            read_idx_next   = read_idx_adv;
            head_start_next = desc_start_reg[read_idx_adv];
            head_end_next   = desc_end_reg[read_idx_adv];
        end
    end

    // Form the result from the updated state
    always_comb
    begin
        res.status      = status;
        res.head_valid  = (write_idx_next != read_idx_next);
        res.burst_start = burst_start_next;
        if (res.head_valid)
        begin
            res.head_start  = head_start_next;
            res.head_length = rfdr_pkg::LEN_W'(head_end_next)
                              - rfdr_pkg::LEN_W'(head_start_next)
                              + rfdr_pkg::LEN_W'(1);
        end
        else
        begin
            res.head_start  = '0;
            res.head_length = '0;
        end
    end

    // Hold the ring state; advance it as each request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_idx_reg   <= '0;
            read_idx_reg    <= '0;
            burst_start_reg <= '0;
            head_start_reg  <= '0;
            head_end_reg    <= '0;
            for (int i = 0; i < rfdr_pkg::DESC_COUNT; i++)
            begin
                desc_start_reg[i] <= '0;
                desc_end_reg[i]   <= '0;
            end
        end
        else if (step)
        begin
            write_idx_reg   <= write_idx_next;
            read_idx_reg    <= read_idx_next;
            burst_start_reg <= burst_start_next;
            head_start_reg  <= head_start_next;
            head_end_reg    <= head_end_next;
            if (commit)
            begin
                desc_start_reg[write_idx_reg] <= burst_start_reg;
                desc_end_reg[write_idx_reg]   <= frame_end;
            end
        end
    end

endmodule

>>> tb/rfdr_ring_checker.sv
// Scoreboard for the receive frame descriptor ring: mirrors the ring state,
// predicts one result per accepted request and compares the results in order.
// Depends on rfdr_pkg, rfdr_event_if and rfdr_result_if.
module rfdr_ring_checker (
    input  logic   clk,
    input  logic   rst_n,
    rfdr_event_if  ev,
    rfdr_result_if res,
    output int     mismatches,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rfdr_pkg::*;

    typedef logic [LEN_W-1:0] len_t;

    // Mirror of the descriptor ring
    offs_t   frame_first [DESC_COUNT];
    offs_t   frame_last  [DESC_COUNT];
    idx_t    fill_slot;
    idx_t    oldest_slot;

    result_t ring_results [$];
    result_t want;
    int      fault_total = 0;

    function automatic idx_t slot_after(input idx_t slot);
        return idx_t'((int'(slot) + 1) % DESC_COUNT);
    endfunction

    // Apply one request to the mirror and return the result it should give
    function automatic result_t predict_ring_event(input logic cmd,
                                                   input logic [BYTES_W-1:0] nbytes);
        int      count;
        int      last_byte;
        int      next_first;
        idx_t    next_slot;
        logic    full;
        logic    overlap;
        result_t r;
        r.status = STATUS_NONE;
        if (cmd == CMD_BURST_END)
        begin
            if (nbytes != '0)
            begin
                // Clamp the burst and the frame end to what the buffer allows
                count = (int'(nbytes) > BURST_BYTES) ? BURST_BYTES : int'(nbytes);
                last_byte = int'(frame_first[fill_slot]) + count - 1;
                if (last_byte > BUF_BYTES - 1)
                    last_byte = BUF_BYTES - 1;
                next_first = last_byte + 1;
                next_slot  = slot_after(fill_slot);
                full       = (next_slot == oldest_slot);
                overlap    = 1'b0;
                // Wrap when a whole burst no longer fits, and test the oldest frame
                if (next_first + BURST_BYTES - 1 > BUF_BYTES - 1)
                begin
                    next_first = 0;
                    overlap = (BURST_BYTES - 1 >= int'(frame_first[oldest_slot]));
                end
                if (full)
                    r.status = STATUS_RING_FULL;
                else if (overlap)
                    r.status = STATUS_COLLIDE;
                else
                begin
                    frame_last[fill_slot] = offs_t'(last_byte);
                    fill_slot = next_slot;
                    frame_first[fill_slot] = offs_t'(next_first);
                    r.status = STATUS_COMMIT;
                end
            end
        end
        else if (fill_slot != oldest_slot)
            oldest_slot = slot_after(oldest_slot);

        r.head_valid = (fill_slot != oldest_slot);
        if (r.head_valid)
        begin
            r.head_start  = frame_first[oldest_slot];
            r.head_length = len_t'(int'(frame_last[oldest_slot])
                                   - int'(frame_first[oldest_slot]) + 1);
        end
        else
        begin
            r.head_start  = '0;
            r.head_length = '0;
        end
        r.burst_start = frame_first[fill_slot];
        return r;
    endfunction

    task automatic check_field(input string label, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (act_val !== exp_val)
        begin
            fault_total++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                     $time, label, exp_val, act_val);
        end
    endtask

    // Record requests, then match results against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DESC_COUNT; i++)
            begin
                frame_first[i] = '0;
                frame_last[i]  = '0;
            end
            fill_slot   = '0;
            oldest_slot = '0;
            ring_results.delete();
            pending    <= 0;
            mismatches <= fault_total;
        end
        else
        begin
            if (ev.valid && ev.ready)
                ring_results.push_back(predict_ring_event(ev.cmd, ev.received_bytes));
            if (res.valid && res.ready)
            begin
                if (ring_results.size() == 0)
                begin
                    fault_total++;
                    $display("%0t ns: unexpected result: expected none, actual status %0d",
                             $time, res.status);
                end
                else
                begin
                    want = ring_results.pop_front();
                    check_field("status", 16'(want.status), 16'(res.status));
                    check_field("head_valid", 16'(want.head_valid), 16'(res.head_valid));
                    check_field("head_start", 16'(want.head_start), 16'(res.head_start));
                    check_field("head_length", 16'(want.head_length), 16'(res.head_length));
                    check_field("burst_start", 16'(want.burst_start), 16'(res.burst_start));
                end
            end
            pending    <= ring_results.size();
            mismatches <= fault_total;
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the descriptor ring testbench: clock, reset, request and result
// traffic with idling phases, watchdog and verdict.
// Depends on rfdr_pkg, both channel interfaces, the ring and rfdr_ring_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfdr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int PHASE_EVENTS    = 200;
    localparam int PRESSURE_EVENTS = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rfdr_event_if  ev ();
    rfdr_result_if res ();

    int mismatches;
    int pending;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int quiet_cycles = 0;
    bit hold_off_req = 1'b0;
    bit hold_off_served = 1'b0;

    always #2 clk = ~clk;

    rx_frame_descriptor_ring DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_ch  (ev),
        .result_ch (res)
    );

    rfdr_ring_checker ring_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev         (ev),
        .res        (res),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Offer one request, idling first at the current rate, and hold until taken
    task automatic send_event(input logic cmd, input logic [BYTES_W-1:0] nbytes);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            ev.valid <= 1'b0;
            @(posedge clk);
        end
        ev.valid          <= 1'b1;
        ev.cmd            <= cmd;
        ev.received_bytes <= nbytes;
        do
            @(posedge clk);
        while (!ev.ready);
    endtask

    // Bursts of varied size mixed with releases at the given rate to keep the ring moving
    task automatic send_random_event(input int release_pct);
        int                 pick;
        logic [BYTES_W-1:0] nbytes;
        pick = $urandom_range(99);
        if (pick < 8)
            nbytes = '0;
        else if (pick < 20)
            nbytes = BYTES_W'($urandom_range(511, BURST_BYTES + 1));
        else if (pick < 50)
            nbytes = BYTES_W'(BURST_BYTES);
        else
            nbytes = BYTES_W'($urandom_range(BURST_BYTES - 1, 1));
        if ($urandom_range(99) < release_pct)
            send_event(CMD_RELEASE, BYTES_W'($urandom_range(511)));
        else
            send_event(CMD_BURST_END, nbytes);
    endtask

    // Receiver: random stalls, plus one long hold-off when asked
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_served)
            begin
                res.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_served = 1'b1;
            end
            else
                res.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (ev.valid && ev.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        ev.valid          = 1'b0;
        ev.cmd            = CMD_BURST_END;
        ev.received_bytes = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: release on empty ring, zero count, fill the ring with small frames and full bursts
        send_event(CMD_RELEASE, '0);
        send_event(CMD_BURST_END, '0);
        repeat (5) send_event(CMD_BURST_END, 9'd1);
        send_event(CMD_BURST_END, BYTES_W'(BURST_BYTES));
        send_event(CMD_BURST_END, BYTES_W'(BURST_BYTES));
        // Ring full while the burst would also wrap onto the oldest frame
        send_event(CMD_BURST_END, 9'd511);
        // Ring full without wrapping
        send_event(CMD_BURST_END, 9'd3);
        // Free one slot; an oversized burst now wraps onto the oldest frame
        send_event(CMD_RELEASE, '0);
        send_event(CMD_BURST_END, 9'd300);
        // Drain the ring, release once more on empty, then wrap cleanly
        repeat (6) send_event(CMD_RELEASE, '0);
        send_event(CMD_RELEASE, 9'd511);
        send_event(CMD_BURST_END, BYTES_W'(BURST_BYTES));
        send_event(CMD_BURST_END, 9'd257);

        // Random phases: no idling, sender idle, receiver stall, both
        for (int mode = 0; mode < 4; mode++)
        begin
            src_idle_pct   = (mode == 1) ? 76 : (mode == 3) ? 19 : 0;
            sink_stall_pct = (mode == 2) ? 76 : (mode == 3) ? 19 : 0;
            repeat (PHASE_EVENTS) send_random_event(30 + 10 * mode);
        end

        // Pressure: receiver holds off while the sender keeps offering
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_req   = 1'b1;
        repeat (PRESSURE_EVENTS) send_random_event(40);

        // Drain outstanding results, then allow a few idle cycles
        ev.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rfdr_pkg.sv
hw/rtl/rfdr_event_if.sv
hw/rtl/rfdr_result_if.sv
hw/rtl/rfdr_ring.sv
hw/rtl/rx_frame_descriptor_ring.sv
tb/rfdr_ring_checker.sv
tb/testbench.sv
